[src/mhpq_pkg.sv]
// Package for the max-heap priority queue: shared types, status codes and defaults.
// Used by mhpq_cell, max_heap_priority_queue and the bench; depends on nothing else.
package mhpq_pkg;

  // Width of one stored value.
  localparam int unsigned VAL_W = 32;
  // Default number of cells.
  localparam int unsigned DEPTH_DEF = 64;
  // Width and reset value of the capacity register.
  localparam int unsigned CAP_W = 7;
  localparam logic [CAP_W-1:0] CAP_RST = 7'd64;
  // Width of the status field.
  localparam int unsigned STAT_W = 2;
  // Configuration port address width, one 32-bit register at byte address 0.
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;

  // Request kinds carried on in_tuser.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // Register index, taken from the word address bit.
  localparam logic REG_CAPACITY = 1'b0;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic                    ins;
    logic                    rem;
    logic signed [VAL_W-1:0] value;
  } cell_ctl_t;

endpackage

[src/max_heap_priority_queue.sv]
// Max priority queue of signed 32-bit values built as a row of sorted cells.
// Result: a request's result is registered and shown in the cycle after its transaction.
// Throughput: one request per cycle unless the output stalls; cells update in one step.
// Reset: synchronous active-low rst_n empties the queue and sets capacity to 64.
// Cell contents are not reset; only cells below the entry count are ever read.
// Depends on mhpq_pkg and mhpq_cell.
module max_heap_priority_queue #(
  parameter int unsigned DEPTH = mhpq_pkg::DEPTH_DEF,
  parameter int unsigned CNT_W = $clog2(DEPTH + 1),
  parameter int unsigned OUT_W = ((mhpq_pkg::STAT_W + mhpq_pkg::VAL_W + CNT_W + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input channel
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [mhpq_pkg::VAL_W-1:0]     in_tdata,  // [31:0] value
  input  logic                           in_tuser,  // [0] req_type
  // Result channel
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [OUT_W-1:0]               out_tdata, // [1:0] status, [33:2] popped_value,
                                                    // then count, zero padded
  // Configuration port
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [mhpq_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [mhpq_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [mhpq_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                           cfg_pready
);
  import mhpq_pkg::*;

  localparam int unsigned LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [LIM_W-1:0] DEPTH_L = LIM_W'(DEPTH);
  localparam int unsigned PAD_W = OUT_W - STAT_W - VAL_W - CNT_W;

  logic [CAP_W-1:0]        cap_r;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic                    out_valid_r;
  logic [STAT_W-1:0]       status_r;
  logic [STAT_W-1:0]       status_nxt;
  logic signed [VAL_W-1:0] popped_r;
  logic signed [VAL_W-1:0] popped_nxt;
  logic [CNT_W-1:0]        out_count_r;

  logic                    in_fire;
  logic                    cfg_wr;
  logic                    full;
  logic                    empty;
  cell_ctl_t               ctl;

  logic                    ge   [DEPTH+1];
  logic signed [VAL_W-1:0] vals [DEPTH+1];

  // Accept a request whenever the result slot is free or draining.
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  // Full against the smaller of the register and the storage depth.
  assign full  = (LIM_W'(count_r) >= LIM_W'(cap_r)) || (LIM_W'(count_r) >= DEPTH_L);
  assign empty = (count_r == '0);

  // Broadcast the command to the cell row.
  always_comb begin
    ctl.ins   = in_fire && (in_tuser == REQ_INSERT) && !full;
    ctl.rem   = in_fire && (in_tuser == REQ_REMOVE) && !empty;
    ctl.value = $signed(in_tdata);
  end

  // Cell row: head sees an always-ahead neighbor, tail recirculates its own value.
  assign ge[0]          = 1'b1;
  assign vals[0]        = ctl.value;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] nv;
    if (i == DEPTH - 1) begin : g_tail
      assign nv = vals[i+1];
    end else begin : g_mid
      assign nv = vals[i+2];
    end
    mhpq_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .occupied (count_r > CNT_W'(i)),
      .prev_ge  (ge[i]),
      .prev_val (vals[i]),
      .next_val (nv),
      .ge       (ge[i+1]),
      .val      (vals[i+1])
    );
  end

  // Work out the result and the next count.
  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    popped_nxt = '0;
    if (in_tuser == REQ_INSERT) begin
      if (full) begin
        status_nxt = ST_FULL;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        popped_nxt = vals[1];
        count_nxt  = count_r - CNT_W'(1);
      end
    end
  end

  // Hold count, capacity and the result slot.
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cap_r       <= CAP_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        count_r <= count_nxt;
      end
      if (cfg_wr && (cfg_paddr[2] == REG_CAPACITY)) begin
        cap_r <= cfg_pwdata[CAP_W-1:0];
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r    <= status_nxt;
      popped_r    <= popped_nxt;
      out_count_r <= count_nxt;
    end
  end

  // Drive the result channel.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_count_r, popped_r, status_r};

  // Configuration reads.
  assign cfg_pready = 1'b1;
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_CAPACITY) begin
      cfg_prdata = CFG_DW'(cap_r);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    LIM_W'(count_r) <= DEPTH_L)
    else $error("entry count beyond storage");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted request left no result");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_EMPTY) |-> (out_count_r == '0 && popped_r == '0))
    else $error("empty removal reported entries");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && status_nxt != ST_DONE) |=> $stable(count_r))
    else $error("flagged request changed the count");
`endif

endmodule

[src/mhpq_cell.sv]
// One cell of the sorted shift-register queue: holds one value, largest in cell 0.
// Depends on mhpq_pkg for the command struct and value width.
module mhpq_cell (
  input  logic                            clk,
  input  mhpq_pkg::cell_ctl_t             ctl,
  input  logic                            occupied,
  input  logic                            prev_ge,
  input  logic signed [mhpq_pkg::VAL_W-1:0] prev_val,
  input  logic signed [mhpq_pkg::VAL_W-1:0] next_val,
  output logic                            ge,
  output logic signed [mhpq_pkg::VAL_W-1:0] val
);
  import mhpq_pkg::*;

  logic signed [VAL_W-1:0] val_r;
  logic signed [VAL_W-1:0] val_nxt;

  // Mark whether this cell stays ahead of the incoming value.
  assign ge  = occupied && (val_r >= ctl.value);
  assign val = val_r;

  // Insert: keep, take the new value, or take the neighbor's; remove: shift up.
  always_comb begin
    val_nxt = val_r;
    if (ctl.ins) begin
      if (ge) begin
        val_nxt = val_r;
      end else if (prev_ge) begin
        val_nxt = ctl.value;
      end else begin
        val_nxt = prev_val;
      end
    end else if (ctl.rem) begin
      val_nxt = next_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

[bench/max_heap_priority_queue_tb.sv]
// Self-checking bench for max_heap_priority_queue: random and directed insert/remove traffic
// checked against a software max-heap. Depends on mhpq_pkg and the queue RTL only.
module max_heap_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mhpq_pkg::*;

  localparam int unsigned QDEPTH   = DEPTH_DEF;
  localparam int unsigned CNT_BITS = $clog2(QDEPTH + 1);
  localparam int unsigned OUT_BITS = ((STAT_W + VAL_W + CNT_BITS + 7) / 8) * 8;
  localparam logic [CFG_AW-1:0] CAP_ADDR = CFG_AW'(4 * int'(REG_CAPACITY));
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic             kind;
    logic [VAL_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] popped;
    logic [CNT_BITS-1:0]     count;
  } result_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [VAL_W-1:0]    in_tdata;   // [31:0] value
  logic                in_tuser;   // [0] req_type
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_BITS-1:0] out_tdata;  // [1:0] status, [33:2] popped_value, [40:34] count
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CFG_AW-1:0]   cfg_paddr;
  logic [CFG_DW-1:0]   cfg_pwdata;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  // Shadow heap and its configuration
  logic signed [VAL_W-1:0] heap_vals [QDEPTH];
  int unsigned             held;
  int unsigned             cap_shadow;

  request_t    pending_reqs [$];
  result_t     expected_results [$];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned errors;
  int unsigned cycles;
  int unsigned n_inserts, n_removes, n_full, n_empty, n_cap_writes;

  max_heap_priority_queue uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Apply one request to the shadow heap and return the result it should produce
  function automatic result_t apply_request(logic kind, logic signed [VAL_W-1:0] val);
    result_t                 r;
    int unsigned             limit, pos, par, lft, rgt, pick;
    logic signed [VAL_W-1:0] tmp;
    r.status = ST_DONE;
    r.popped = '0;
    limit = (cap_shadow < QDEPTH) ? cap_shadow : QDEPTH;
    if (kind == REQ_INSERT) begin
      if (held >= limit) begin
        r.status = ST_FULL;
      end else begin
        // append and sift up while strictly greater than the parent
        pos = held;
        heap_vals[pos] = val;
        held++;
        while (pos > 0) begin
          par = (pos - 1) / 2;
          if (heap_vals[pos] <= heap_vals[par]) break;
          tmp = heap_vals[pos];
          heap_vals[pos] = heap_vals[par];
          heap_vals[par] = tmp;
          pos = par;
        end
      end
    end else begin
      if (held == 0) begin
        r.status = ST_EMPTY;
      end else begin
        // take the root, move the last entry up and sift it down; left wins ties
        r.popped = heap_vals[0];
        held--;
        heap_vals[0] = heap_vals[held];
        pos = 0;
        forever begin
          lft = 2 * pos + 1;
          rgt = lft + 1;
          if (lft >= held) break;
          pick = lft;
          if (rgt < held && heap_vals[rgt] > heap_vals[lft]) pick = rgt;
          if (heap_vals[pick] <= heap_vals[pos]) break;
          tmp = heap_vals[pos];
          heap_vals[pos] = heap_vals[pick];
          heap_vals[pick] = tmp;
          pos = pick;
        end
      end
    end
    r.count = CNT_BITS'(held);
    return r;
  endfunction

  // Driver: present pending requests, predict each accepted transaction
  always @(posedge clk) begin
    request_t req;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(apply_request(in_tuser, in_tdata));
      end
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          req = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= req.kind;
          in_tdata  <= req.value;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random, check each result transaction against the oldest prediction
  always @(posedge clk) begin
    result_t                 want;
    logic [STAT_W-1:0]       got_status;
    logic signed [VAL_W-1:0] got_popped;
    logic [CNT_BITS-1:0]     got_count;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (out_tvalid && out_tready) begin
        got_status = out_tdata[STAT_W-1:0];
        got_popped = out_tdata[STAT_W +: VAL_W];
        got_count  = out_tdata[STAT_W + VAL_W +: CNT_BITS];
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result status=%0d popped=%0d count=%0d",
                   $time, got_status, got_popped, got_count);
        end else begin
          want = expected_results.pop_front();
          if (want.status == ST_FULL) n_full++;
          if (want.status == ST_EMPTY) n_empty++;
          if (got_status !== want.status || got_popped !== want.popped ||
              got_count !== want.count) begin
            errors++;
            $display("%0t: mismatch expected status=%0d popped=%0d count=%0d, got %0d %0d %0d",
                     $time, want.status, want.popped, want.count,
                     got_status, got_popped, got_count);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
      $display("** max_heap_priority_queue: FAILED **");
      $finish;
    end
  end

  task automatic add_request(input logic kind, input logic [VAL_W-1:0] val);
    request_t req;
    req.kind  = kind;
    req.value = val;
    pending_reqs.push_back(req);
    if (kind == REQ_INSERT) n_inserts++;
    else n_removes++;
  endtask

  // Mostly full-range values, with extremes and a narrow band that forces ties
  function automatic logic [VAL_W-1:0] random_value();
    logic [VAL_W-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       v = 32'h7FFF_FFFF;
          1:       v = 32'h8000_0000;
          2:       v = 32'h0000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      1, 2, 3: v = VAL_W'($urandom_range(0, 15)) - VAL_W'(8);
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // Runs of inserts and removals long enough to reach full and empty, plus mixed noise
  task automatic queue_random_mix(input int unsigned n_items, input int unsigned cap);
    int unsigned made, pick, run_len, k;
    made = 0;
    while (made < n_items) begin
      pick = $urandom_range(0, 9);
      run_len = (pick < 7) ? $urandom_range(1, cap + 4) : $urandom_range(1, 20);
      for (k = 0; k < run_len && made < n_items; k++) begin
        if (pick < 4) add_request(REQ_INSERT, random_value());
        else if (pick < 7) add_request(REQ_REMOVE, $urandom());
        else add_request($urandom_range(0, 1) ? REQ_REMOVE : REQ_INSERT, random_value());
        made++;
      end
    end
  endtask

  // Wait until every request is sent and answered, sampling once the edge has settled
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(negedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write the capacity register, then read it back
  task automatic set_capacity(input int unsigned cap);
    logic [CFG_DW-1:0] rd;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CAP_ADDR;
    cfg_pwdata  <= CFG_DW'(cap);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cap_shadow = cap;
    n_cap_writes++;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (rd !== CFG_DW'(cap)) begin
      errors++;
      $display("%0t: capacity readback expected %0d got %0d", $time, cap, rd);
    end
    @(posedge clk);
  endtask

  // Stimulus sequence
  initial begin
    int unsigned seg;
    int unsigned seg_caps [6];
    seg_caps    = '{64, 9, 1, 64, 37, 64};
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= REQ_INSERT;
    out_tready  <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    cycles = 0;
    errors = 0;
    held = 0;
    cap_shadow = CAP_RST;
    n_inserts = 0;
    n_removes = 0;
    n_full = 0;
    n_empty = 0;
    n_cap_writes = 0;
    send_idle_pct = 8;
    recv_stall_pct = 75;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: removal from empty, extremes and ties at reset capacity
    add_request(REQ_REMOVE, 32'hDEAD_BEEF);
    add_request(REQ_INSERT, 32'h7FFF_FFFF);
    add_request(REQ_INSERT, 32'h8000_0000);
    add_request(REQ_INSERT, 32'h0000_0000);
    add_request(REQ_INSERT, 32'hFFFF_FFFF);
    add_request(REQ_INSERT, 32'h7FFF_FFFF);
    add_request(REQ_INSERT, 32'h0000_0001);
    add_request(REQ_REMOVE, 32'h0);
    add_request(REQ_REMOVE, 32'hFFFF_FFFF);
    add_request(REQ_REMOVE, 32'h0);
    wait_drained();

    // Capacity lowered below the count: inserts drop, removals still work
    set_capacity(2);
    add_request(REQ_INSERT, 32'h0000_0005);
    add_request(REQ_REMOVE, 32'h0);
    add_request(REQ_REMOVE, 32'h0);
    add_request(REQ_INSERT, 32'h8000_0001);
    add_request(REQ_INSERT, 32'h0000_0007);
    wait_drained();

    // Capacity zero: every insert drops; drain to empty
    set_capacity(0);
    add_request(REQ_INSERT, 32'h1234_5678);
    add_request(REQ_REMOVE, 32'h0);
    add_request(REQ_REMOVE, 32'h0);
    add_request(REQ_REMOVE, 32'h0);
    wait_drained();

    // Random segments; contents carry over so capacity changes can land below the count
    for (seg = 0; seg < 6; seg++) begin
      send_idle_pct  = (seg < 2) ? 8 : (seg < 4) ? 75 : 0;
      recv_stall_pct = (seg < 2) ? 75 : (seg < 4) ? 8 : 0;
      set_capacity(seg_caps[seg]);
      queue_random_mix(305, seg_caps[seg]);
      wait_drained();
    end

    repeat (8) @(posedge clk);
    $display("Ran %0d inserts (%0d dropped as full) and %0d removals (%0d from empty)",
             n_inserts, n_full, n_removes, n_empty);
    $display("over %0d capacity settings in %0d cycles", n_cap_writes, cycles);
    if (errors == 0) begin
      $display("** max_heap_priority_queue: PASSED **");
    end else begin
      $display("** max_heap_priority_queue: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
src/mhpq_pkg.sv
src/mhpq_cell.sv
src/max_heap_priority_queue.sv
bench/max_heap_priority_queue_tb.sv
